@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers for the rtl, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies a delayed consequent, the delay given by n
`define ASSERT_DELAY(label, clk, rst, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_DELAY(label, clk, rst, ante, n, cons)

`endif

`endif

@@ rtl/swrmf_pkg.sv @@
// ---------------------------------------------------------------------------
// swrmf_pkg
// types and constants of the shallow-water momentum flux block
// ---------------------------------------------------------------------------
package swrmf_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int Q_W           = 64;
  localparam int ROOT_W_DEF    = (63 + FRAC_BITS_DEF) / 2;

  typedef logic signed [Q_W-1:0] q_t;

  // internal clip level, +-(2^62-1)
  localparam q_t LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [DATA_W-1:0] vel_left;
    logic signed [DATA_W-1:0] vel_right;
    logic signed [DATA_W-1:0] depth_left;
    logic signed [DATA_W-1:0] depth_right;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] flux;
    logic                     saturated;
  } out_t;

endpackage

@@ rtl/shallow_water_rusanov_momentum_flux.sv @@
// ---------------------------------------------------------------------------
// shallow_water_rusanov_momentum_flux
// rusanov momentum flux of one shallow-water cell interface, fixed point
// ---------------------------------------------------------------------------
// A new interface transaction is taken on every clock cycle (busy is high
// only during reset) and its result appears on result, flagged by strobe for
// exactly one cycle. The delay to the result is set by the two square-root
// cell chains, one cell per root bit, which run beside the momentum and
// pressure products. The receiver cannot stall the block: every strobe must
// be taken. A dry interface (both depths zero or negative) gives flux 0
// without the flag; otherwise any internal clip or a flux outside the 32-bit
// range sets saturated.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module shallow_water_rusanov_momentum_flux #(
  parameter int FRAC_BITS = swrmf_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  swrmf_pkg::in_t   item,
  output logic             strobe,
  output swrmf_pkg::out_t  result
);
  import swrmf_pkg::*;

  localparam int ROOT_W = (63 + FRAC_BITS) / 2;
  localparam int X_W    = 2 * ROOT_W;
  localparam int LAT    = ROOT_W + 6;

  // gravity and half gravity in fixed point
  localparam q_t GQ  = q_t'(((64'd981 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam q_t HGQ = q_t'(((64'd981 << FRAC_BITS) + 64'd100) / 64'd200);

  localparam logic signed [Q_W:0] LIM_X  = 65'sh0_3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [Q_W:0] FMAX_X = (65'sd1 <<< (DATA_W - 1)) - 65'sd1;
  localparam logic signed [Q_W:0] FMIN_X = -FMAX_X - 65'sd1;

  typedef struct packed {
    q_t   val;
    logic sat;
  } qsat_t;

  // side data that rides along the pipeline
  typedef struct packed {
    logic                     dry;
    logic signed [DATA_W-1:0] vel_l;
    logic signed [DATA_W-1:0] vel_r;
    logic signed [DATA_W-1:0] depth_l;
    logic signed [DATA_W-1:0] depth_r;
    q_t                       dq;
    q_t                       sum;
    q_t                       t1;
    q_t                       t2;
    q_t                       cd;
    logic                     sat;
  } pipe_t;

  // saturating add at the internal clip level
  function automatic qsat_t add_clip(input q_t a, input q_t b);
    logic signed [Q_W:0] s;
    qsat_t               r;
    s = $signed({a[Q_W-1], a}) + $signed({b[Q_W-1], b});
    if (s > LIM_X) begin
      r = '{val: LIM, sat: 1'b1};
    end else if (s < -LIM_X) begin
      r = '{val: -LIM, sat: 1'b1};
    end else begin
      r = '{val: q_t'(s[Q_W-1:0]), sat: 1'b0};
    end
    return r;
  endfunction

  logic accept;
  logic [LAT-1:1] vld;
  pipe_t pipe      [1:LAT-1];
  pipe_t pipe_next [1:LAT-1];
  pipe_t head;

  // first products
  q_t hl_pos, hr_pos, ul_in, ur_in, hl_in, hr_in;
  q_t p_l, p_r, q_l, q_r, a_l, a_r;
  logic sp_l, sp_r, sq_l, sq_r, sa_l, sa_r;

  // second products
  q_t ul_2, ur_2, hl_2, hr_2;
  q_t s_l, s_r, h_l, h_r;
  logic ss_l, ss_r, sh_l, sh_r;

  // square-root chains
  logic [X_W-1:0]    rem_l  [0:ROOT_W];
  logic [X_W-1:0]    rem_r  [0:ROOT_W];
  logic [ROOT_W-1:0] root_l [0:ROOT_W];
  logic [ROOT_W-1:0] root_r [0:ROOT_W];

  // wave speed and final product
  q_t   m;
  logic sm;

  qsat_t dq_c, s5_c, s6_c, s7_c;
  q_t    half7, cl, cr, cd_c, ul_a, ur_a;
  logic signed [Q_W:0] fin;
  out_t  result_next;

  // every cycle is a transaction slot, reset holds the port off
  assign busy   = rst;
  assign accept = start && !busy;

  // ---------------- stage 1: operands and first multiplies ----------------
  always_comb begin
    ul_in  = q_t'(item.vel_left);
    ur_in  = q_t'(item.vel_right);
    hl_in  = q_t'(item.depth_left);
    hr_in  = q_t'(item.depth_right);
    hl_pos = (item.depth_left > 0)  ? hl_in : '0;
    hr_pos = (item.depth_right > 0) ? hr_in : '0;

    head         = '0;
    head.dry     = (item.depth_left <= 0) && (item.depth_right <= 0);
    head.vel_l   = item.vel_left;
    head.vel_r   = item.vel_right;
    head.depth_l = item.depth_left;
    head.depth_r = item.depth_right;
  end

  // g*h under the roots
  swrmf_mulq #(.FRAC_BITS(FRAC_BITS)) u_pl (.clk, .a(GQ), .b(hl_pos), .p(p_l), .sat(sp_l));
  swrmf_mulq #(.FRAC_BITS(FRAC_BITS)) u_pr (.clk, .a(GQ), .b(hr_pos), .p(p_r), .sat(sp_r));
  // momenta q = u*h
  swrmf_mulq #(.FRAC_BITS(FRAC_BITS)) u_ql (.clk, .a(ul_in), .b(hl_in), .p(q_l), .sat(sq_l));
  swrmf_mulq #(.FRAC_BITS(FRAC_BITS)) u_qr (.clk, .a(ur_in), .b(hr_in), .p(q_r), .sat(sq_r));
  // half gravity times depth
  swrmf_mulq #(.FRAC_BITS(FRAC_BITS)) u_al (.clk, .a(HGQ), .b(hl_in), .p(a_l), .sat(sa_l));
  swrmf_mulq #(.FRAC_BITS(FRAC_BITS)) u_ar (.clk, .a(HGQ), .b(hr_in), .p(a_r), .sat(sa_r));

  // ---------------- stage 2: second multiplies, momentum jump -------------
  always_comb begin
    ul_2 = q_t'(pipe[2].vel_l);
    ur_2 = q_t'(pipe[2].vel_r);
    hl_2 = q_t'(pipe[2].depth_l);
    hr_2 = q_t'(pipe[2].depth_r);
    dq_c = add_clip(q_r, -q_l);
  end

  // u*q advection terms
  swrmf_mulq #(.FRAC_BITS(FRAC_BITS)) u_sl (.clk, .a(ul_2), .b(q_l), .p(s_l), .sat(ss_l));
  swrmf_mulq #(.FRAC_BITS(FRAC_BITS)) u_sr (.clk, .a(ur_2), .b(q_r), .p(s_r), .sat(ss_r));
  // g/2*h^2 pressure terms
  swrmf_mulq #(.FRAC_BITS(FRAC_BITS)) u_hl (.clk, .a(a_l), .b(hl_2), .p(h_l), .sat(sh_l));
  swrmf_mulq #(.FRAC_BITS(FRAC_BITS)) u_hr (.clk, .a(a_r), .b(hr_2), .p(h_r), .sat(sh_r));

  // ---------------- square roots, one cell per result bit ------------------
  // radicand is g*h scaled up by the fraction bits, always non-negative
  assign rem_l[0]  = X_W'(p_l) << FRAC_BITS;
  assign rem_r[0]  = X_W'(p_r) << FRAC_BITS;
  assign root_l[0] = '0;
  assign root_r[0] = '0;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_root
    swrmf_sqrt_cell #(.ROOT_W(ROOT_W), .BIT(ROOT_W - 1 - i)) u_cell_l (
      .clk,
      .rem_i  (rem_l[i]),
      .root_i (root_l[i]),
      .rem_o  (rem_l[i+1]),
      .root_o (root_l[i+1])
    );
    swrmf_sqrt_cell #(.ROOT_W(ROOT_W), .BIT(ROOT_W - 1 - i)) u_cell_r (
      .clk,
      .rem_i  (rem_r[i]),
      .root_i (root_r[i]),
      .rem_o  (rem_r[i+1]),
      .root_o (root_r[i+1])
    );
  end

  // ---------------- flux sum, in the model's order -------------------------
  always_comb begin
    s5_c  = add_clip(s_l, h_l);
    s6_c  = add_clip(pipe[5].sum, pipe[5].t1);
    s7_c  = add_clip(pipe[6].sum, pipe[6].t2);
    // halve, rounding toward zero
    half7 = (s7_c.val + (s7_c.val[Q_W-1] ? q_t'(1) : q_t'(0))) >>> 1;
  end

  // ---------------- wave speed: max(|u| + sqrt(g*h)) / 2 -------------------
  always_comb begin
    ul_a = pipe[ROOT_W+2].vel_l[DATA_W-1] ? -q_t'(pipe[ROOT_W+2].vel_l)
                                         : q_t'(pipe[ROOT_W+2].vel_l);
    ur_a = pipe[ROOT_W+2].vel_r[DATA_W-1] ? -q_t'(pipe[ROOT_W+2].vel_r)
                                         : q_t'(pipe[ROOT_W+2].vel_r);
    cl   = ul_a + q_t'(root_l[ROOT_W]);
    cr   = ur_a + q_t'(root_r[ROOT_W]);
    cd_c = ((cl >= cr) ? cl : cr) >>> 1;
  end

  // wave speed times momentum jump
  swrmf_mulq #(.FRAC_BITS(FRAC_BITS)) u_m (
    .clk,
    .a   (pipe[ROOT_W+3].cd),
    .b   (pipe[ROOT_W+3].dq),
    .p   (m),
    .sat (sm)
  );

  // ---------------- final subtract and range clip --------------------------
  always_comb begin
    fin = $signed({pipe[LAT-1].sum[Q_W-1], pipe[LAT-1].sum}) - $signed({m[Q_W-1], m});
    if (pipe[LAT-1].dry) begin
      result_next = '{flux: '0, saturated: 1'b0};
    end else if (fin > FMAX_X) begin
      result_next = '{flux: FMAX_X[DATA_W-1:0], saturated: 1'b1};
    end else if (fin < FMIN_X) begin
      result_next = '{flux: FMIN_X[DATA_W-1:0], saturated: 1'b1};
    end else begin
      // inside the 32-bit range, saturated reports the earlier internal clips
      result_next = '{flux: fin[DATA_W-1:0], saturated: pipe[LAT-1].sat | sm};
    end
  end

  // ---------------- pipeline registers -------------------------------------
  always_comb begin
    pipe_next[1] = head;
    for (int k = 2; k < LAT; k++) begin
      pipe_next[k] = pipe[k-1];
    end
    // momentum jump and first-product clips
    pipe_next[3].dq  = dq_c.val;
    pipe_next[3].sat = pipe[2].sat | sp_l | sp_r | sq_l | sq_r | sa_l | sa_r | dq_c.sat;
    // running sum
    pipe_next[5].sum = s5_c.val;
    pipe_next[5].t1  = s_r;
    pipe_next[5].t2  = h_r;
    pipe_next[5].sat = pipe[4].sat | ss_l | ss_r | sh_l | sh_r | s5_c.sat;
    pipe_next[6].sum = s6_c.val;
    pipe_next[6].sat = pipe[5].sat | s6_c.sat;
    pipe_next[7].sum = half7;
    pipe_next[7].sat = pipe[6].sat | s7_c.sat;
    // half wave speed
    pipe_next[ROOT_W+3].cd = cd_c;
  end

  always_ff @(posedge clk) begin
    pipe   <= pipe_next;
    result <= result_next;
  end

  // transaction tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      strobe <= 1'b0;
    end else begin
      vld    <= {vld[LAT-2:1], accept};
      strobe <= vld[LAT-1];
    end
  end

  // ---------------- checks -------------------------------------------------
  `ASSERT_DELAY(a_latency, clk, rst, accept, LAT, strobe)
  `ASSERT_IMPL(a_no_spurious, clk, rst, strobe, $past(accept, LAT))
  `ASSERT_DELAY(a_dry_zero, clk, rst, accept && head.dry, LAT, (result.flux == 0) && !result.saturated)

endmodule

@@ rtl/swrmf_mulq.sv @@
// ---------------------------------------------------------------------------
// swrmf_mulq
// two-stage fixed-point multiply: 32x32 partial products, then shift and clip
// ---------------------------------------------------------------------------
module swrmf_mulq #(
  parameter int FRAC_BITS = swrmf_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  swrmf_pkg::q_t  a,
  input  swrmf_pkg::q_t  b,
  output swrmf_pkg::q_t  p,
  output logic           sat
);
  import swrmf_pkg::*;

  logic [Q_W-1:0]   ma, mb;
  logic [Q_W-1:0]   pp00, pp01, pp10, pp11;
  logic             neg;
  logic [2*Q_W-1:0] full, sh;
  logic             over;
  q_t               m;

  // sign and magnitude
  assign ma = a[Q_W-1] ? Q_W'(-a) : Q_W'(a);
  assign mb = b[Q_W-1] ? Q_W'(-b) : Q_W'(b);

  always_ff @(posedge clk) begin
    pp00 <= Q_W'(ma[31:0])  * Q_W'(mb[31:0]);
    pp01 <= Q_W'(ma[31:0])  * Q_W'(mb[63:32]);
    pp10 <= Q_W'(ma[63:32]) * Q_W'(mb[31:0]);
    pp11 <= Q_W'(ma[63:32]) * Q_W'(mb[63:32]);
    neg  <= a[Q_W-1] ^ b[Q_W-1];
  end

  always_comb begin
    full = (2*Q_W)'(pp00) + (((2*Q_W)'(pp01) + (2*Q_W)'(pp10)) << 32)
         + ((2*Q_W)'(pp11) << 64);
    sh   = full >> FRAC_BITS;
    over = sh > (2*Q_W)'(LIM);
    m    = over ? LIM : q_t'(sh[Q_W-1:0]);
  end

  always_ff @(posedge clk) begin
    p   <= neg ? -m : m;
    sat <= over;
  end

endmodule

@@ rtl/swrmf_sqrt_cell.sv @@
// ---------------------------------------------------------------------------
// swrmf_sqrt_cell
// one bit of a restoring square root, registered toward the next cell
// ---------------------------------------------------------------------------
module swrmf_sqrt_cell #(
  parameter int ROOT_W = swrmf_pkg::ROOT_W_DEF,
  parameter int BIT    = 0
) (
  input  logic                  clk,
  input  logic [2*ROOT_W-1:0]   rem_i,
  input  logic [ROOT_W-1:0]     root_i,
  output logic [2*ROOT_W-1:0]   rem_o,
  output logic [ROOT_W-1:0]     root_o
);
  localparam int X_W = 2 * ROOT_W;
  localparam int D_W = X_W + 1;

  logic [D_W-1:0] d;
  logic           take;

  // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
  always_comb begin
    d    = (D_W'(root_i) << (BIT + 1)) | (D_W'(1) << (2 * BIT));
    take = {1'b0, rem_i} >= d;
  end

  always_ff @(posedge clk) begin
    rem_o  <= take ? rem_i - d[X_W-1:0] : rem_i;
    root_o <= take ? (root_i | (ROOT_W'(1) << BIT)) : root_i;
  end

endmodule
